// ----- src/pst_pkg.sv -----
`timescale 1ns / 1ps

package pst_pkg;

   localparam int DEFAULT_TABLE_ENTRIES    = 32;
   localparam int DEFAULT_NANOS_PER_SECOND = 1000000000;

   localparam int ID_W        = 22;
   localparam int SECONDS_W   = 31;
   localparam int NANOS_W     = 30;
   localparam int SLOT_W      = 5;
   // wide enough for a slot number of the largest table (64 entries)
   localparam int TOKEN_SLOT_W = 6;

   typedef enum logic {
      MODE_ADD    = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef struct packed {
      logic                    valid;
      mode_type                mode;
      logic [ID_W-1:0]         proc_id;
      logic [SECONDS_W-1:0]    seconds;
      logic [NANOS_W-1:0]      nanos;
      logic                    found;
      logic [TOKEN_SLOT_W-1:0] slot;
   } token_type;

endpackage

// ----- src/pst_cell.sv -----
`timescale 1ns / 1ps

module pst_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  pst_pkg::token_type tok_in,
   output pst_pkg::token_type tok_out
);
   import pst_pkg::*;

   logic                 occupied_ff, occupied_in;
   logic [ID_W-1:0]      proc_id_ff, proc_id_in;
   logic [SECONDS_W-1:0] seconds_ff, seconds_in;
   logic [NANOS_W-1:0]   nanos_ff, nanos_in;
   logic                 tok_valid_ff, tok_valid_in;
   token_type            tok_ff, tok_in_next;
   logic                 hit;

   always_comb begin
      hit = 1'b0;
      if (tok_in.valid && !tok_in.found) begin
         case (tok_in.mode)
            MODE_ADD:    hit = !occupied_ff;
            MODE_REMOVE: hit = (proc_id_ff == tok_in.proc_id);
            default:     hit = 1'b0;
         endcase
      end

      occupied_in = occupied_ff;
      proc_id_in  = proc_id_ff;
      seconds_in  = seconds_ff;
      nanos_in    = nanos_ff;
      if (hit) begin
         if (tok_in.mode == MODE_ADD) begin
            occupied_in = 1'b1;
            proc_id_in  = tok_in.proc_id;
            seconds_in  = tok_in.seconds;
            nanos_in    = tok_in.nanos;
         end else begin
            occupied_in = 1'b0;
            proc_id_in  = '0;
            seconds_in  = '0;
            nanos_in    = '0;
         end
      end

      tok_in_next = tok_in;
      if (hit) begin
         tok_in_next.found = 1'b1;
         tok_in_next.slot  = TOKEN_SLOT_W'(CELL_INDEX);
      end
      tok_valid_in = tok_in.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff  <= 1'b0;
         proc_id_ff   <= '0;
         seconds_ff   <= '0;
         nanos_ff     <= '0;
         tok_valid_ff <= 1'b0;
      end else begin
         occupied_ff  <= occupied_in;
         proc_id_ff   <= proc_id_in;
         seconds_ff   <= seconds_in;
         nanos_ff     <= nanos_in;
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in_next;
   end

   always_comb begin
      tok_out       = tok_ff;
      tok_out.valid = tok_valid_ff;
   end

endmodule

// ----- src/process_slot_table.sv -----
`timescale 1ns / 1ps
// channel  | valid      | stall      | payload
// ---------+------------+------------+-----------------------------------------------
// request  | req_valid  | req_stall  | req_mode, req_proc_id, req_clock_seconds/nanos
// response | rsp_valid  | rsp_stall  | rsp_slot_index, rsp_success
//
// A request beat walks the row of slot cells, one cell per cycle; its response
// is registered from the beat that leaves the last cell.
// One request is in flight at a time: req_stall stays high from acceptance
// until the response beat is taken, so no new request is taken before then.
// rsp_stall, by holding the response, holds off the next request further.
// Reset clears every slot at once; requests are taken the cycle after reset.

module process_slot_table #(
   parameter int TABLE_ENTRIES    = pst_pkg::DEFAULT_TABLE_ENTRIES,
   parameter int NANOS_PER_SECOND = pst_pkg::DEFAULT_NANOS_PER_SECOND
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_mode,
   input  logic [pst_pkg::ID_W-1:0]         req_proc_id,
   input  logic [pst_pkg::SECONDS_W-1:0]    req_clock_seconds,
   input  logic [pst_pkg::NANOS_W-1:0]      req_clock_nanos,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [pst_pkg::SLOT_W-1:0]       rsp_slot_index,
   output logic                             rsp_success
);
   import pst_pkg::*;

   logic                busy_ff, busy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                rsp_success_ff, rsp_success_in;
   logic                req_accept;
   logic                rsp_accept;
   token_type           launch;
   token_type           chain_tok [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] chain_valid;
   token_type           last_tok;

   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !busy_ff;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   always_comb begin
      launch         = '0;
      launch.valid   = req_accept;
      launch.mode    = mode_type'(req_mode);
      launch.proc_id = req_proc_id;
      if (req_clock_nanos == NANOS_W'(NANOS_PER_SECOND)) begin
         launch.seconds = req_clock_seconds + SECONDS_W'(1);
         launch.nanos   = '0;
      end else begin
         launch.seconds = req_clock_seconds;
         launch.nanos   = req_clock_nanos;
      end
      launch.found = 1'b0;
      launch.slot  = '0;
   end

   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      if (k == 0) begin : g_first
         pst_cell #(
            .CELL_INDEX(k)
         ) u_cell (
            .clock  (clock),
            .reset  (reset),
            .tok_in (launch),
            .tok_out(chain_tok[k])
         );
      end else begin : g_next
         pst_cell #(
            .CELL_INDEX(k)
         ) u_cell (
            .clock  (clock),
            .reset  (reset),
            .tok_in (chain_tok[k-1]),
            .tok_out(chain_tok[k])
         );
      end
      assign chain_valid[k] = chain_tok[k].valid;
   end

   assign last_tok = chain_tok[TABLE_ENTRIES-1];

   always_comb begin
      busy_in        = busy_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_success_in = rsp_success_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end
      if (rsp_accept) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b0;
      end
      if (last_tok.valid) begin
         rsp_valid_in   = 1'b1;
         rsp_success_in = last_tok.found;
         rsp_slot_in    = last_tok.found ? last_tok.slot[SLOT_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_slot_ff    <= rsp_slot_in;
      rsp_success_ff <= rsp_success_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_success    = rsp_success_ff;

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      ($countones(chain_valid) + 32'(rsp_valid_ff)) <= 1)
      else $error("more than one request beat in flight");

   a_launch: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> chain_valid[0])
      else $error("accepted request did not enter the first cell");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(last_tok.valid))
      else $error("response without a beat leaving the last cell");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (chain_valid == '0) && !rsp_valid_ff)
      else $error("beat in flight while idle");

endmodule

// ----- tb/tb_process_slot_table.sv -----
`timescale 1ns / 1ps

module tb_process_slot_table;
   import pst_pkg::*;

   localparam int SLOTS       = DEFAULT_TABLE_ENTRIES;
   localparam int ONE_SECOND  = DEFAULT_NANOS_PER_SECOND;
   localparam int NANOS_MAX   = (1 << NANOS_W) - 1;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_index;
      logic              success;
   } slot_answer_t;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_stall;
   logic                 req_mode          = MODE_ADD;
   logic [ID_W-1:0]      req_proc_id       = '0;
   logic [SECONDS_W-1:0] req_clock_seconds = '0;
   logic [NANOS_W-1:0]   req_clock_nanos   = '0;
   logic                 rsp_valid;
   logic                 rsp_stall         = 1'b0;
   logic [SLOT_W-1:0]    rsp_slot_index;
   logic                 rsp_success;

   logic                 slot_busy  [SLOTS];
   logic [ID_W-1:0]      slot_owner [SLOTS];
   logic [SECONDS_W-1:0] slot_sec   [SLOTS];
   logic [NANOS_W-1:0]   slot_ns    [SLOTS];

   slot_answer_t pending_answers[$];
   int           mismatches    = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   logic         hold_request  = 1'b0;
   int           hold_left     = 0;
   int           quiet_cycles  = 0;

   process_slot_table u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_proc_id       (req_proc_id),
      .req_clock_seconds (req_clock_seconds),
      .req_clock_nanos   (req_clock_nanos),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_success       (rsp_success)
   );

   always #1 clock = ~clock;

   task automatic clear_slot(input int k);
      slot_busy[k]  = 1'b0;
      slot_owner[k] = '0;
      slot_sec[k]   = '0;
      slot_ns[k]    = '0;
   endtask

   task automatic predict_slot(input mode_type mode, input logic [ID_W-1:0] id,
                               input logic [SECONDS_W-1:0] secs,
                               input logic [NANOS_W-1:0] nanos,
                               output slot_answer_t answer);
      int hit;
      hit = -1;
      if (mode == MODE_ADD) begin
         for (int k = 0; k < SLOTS; k++)
            if (hit < 0 && !slot_busy[k]) hit = k;
         if (hit >= 0) begin
            slot_busy[hit]  = 1'b1;
            slot_owner[hit] = id;
            if (nanos == ONE_SECOND) begin
               slot_sec[hit] = secs + 1'b1;
               slot_ns[hit]  = '0;
            end else begin
               slot_sec[hit] = secs;
               slot_ns[hit]  = nanos;
            end
         end
      end else begin
         for (int k = 0; k < SLOTS; k++)
            if (hit < 0 && slot_owner[k] == id) hit = k;
         if (hit >= 0) clear_slot(hit);
      end
      answer.success    = (hit >= 0);
      answer.slot_index = (hit >= 0) ? SLOT_W'(hit) : '0;
   endtask

   task automatic send_request(input mode_type mode, input logic [ID_W-1:0] id,
                               input logic [SECONDS_W-1:0] secs,
                               input logic [NANOS_W-1:0] nanos);
      slot_answer_t answer;
      logic         taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_proc_id       <= id;
      req_clock_seconds <= secs;
      req_clock_nanos   <= nanos;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         if (taken) begin
            predict_slot(mode, id, secs, nanos, answer);
            pending_answers.push_back(answer);
         end
         @(posedge clock);
      end
   endtask

   task automatic random_request(input int add_pct);
      mode_type             mode;
      logic [ID_W-1:0]      id;
      logic [SECONDS_W-1:0] secs;
      logic [NANOS_W-1:0]   nanos;
      int                   pick;
      mode = ($urandom_range(99) < add_pct) ? MODE_ADD : MODE_REMOVE;
      pick = $urandom_range(99);
      if (mode == MODE_REMOVE && pick < 65)
         id = slot_owner[$urandom_range(SLOTS - 1)];
      else if (pick < 75)
         id = ID_W'($urandom_range(15));
      else
         id = ID_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 8)
         secs = '1;
      else if (pick < 12)
         secs = '0;
      else
         secs = SECONDS_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 15)
         nanos = NANOS_W'(ONE_SECOND);
      else if (pick < 25)
         nanos = NANOS_W'($urandom_range(NANOS_MAX, ONE_SECOND + 1));
      else if (pick < 30)
         nanos = '1;
      else if (pick < 35)
         nanos = '0;
      else
         nanos = NANOS_W'($urandom_range(ONE_SECOND - 1));
      send_request(mode, id, secs, nanos);
   endtask

   task automatic test_directed_edges();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_request(MODE_REMOVE, 22'd5, '0, '0);
      send_request(MODE_REMOVE, '0, '0, '0);
      send_request(MODE_ADD, '1, '1, NANOS_W'(ONE_SECOND));
      send_request(MODE_ADD, '0, '0, '0);
      send_request(MODE_ADD, 22'h2AAAAA, 31'h55555555, NANOS_W'(ONE_SECOND + 1));
      send_request(MODE_ADD, 22'h155555, 31'h2AAAAAAA, '1);
      send_request(MODE_ADD, '1, 31'h12345678, NANOS_W'(ONE_SECOND - 1));
      send_request(MODE_REMOVE, '1, '1, '1);
      send_request(MODE_REMOVE, '0, '0, '0);
      send_request(MODE_ADD, 22'd7, 31'd1, NANOS_W'(ONE_SECOND));
      send_request(MODE_REMOVE, '1, '0, '0);
      send_request(MODE_REMOVE, 22'h123456, '0, '0);
      send_request(MODE_REMOVE, '0, '0, '0);
      send_request(MODE_REMOVE, 22'h2AAAAA, '0, '0);
      send_request(MODE_REMOVE, 22'h155555, '0, '0);
      send_request(MODE_REMOVE, 22'd7, '0, '0);
   endtask

   task automatic test_fill_and_drain();
      send_idle_pct = 20;
      rsp_stall_pct = 20;
      repeat (SLOTS + 3)
         send_request(MODE_ADD, ID_W'($urandom), SECONDS_W'($urandom),
                      NANOS_W'($urandom_range(ONE_SECOND)));
      for (int k = SLOTS - 1; k >= 0; k--)
         if (slot_busy[k]) send_request(MODE_REMOVE, slot_owner[k], '0, '0);
   endtask

   task automatic test_random_phase(input int items, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (items) random_request(55);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = 1'b1;
      repeat (24) random_request(60);
   endtask

   task automatic flag_mismatch(input string what, input slot_answer_t want,
                                input slot_answer_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch (%s): expected slot %0d success %0b, got slot %0d success %0b",
                  what, want.slot_index, want.success, got.slot_index, got.success);
   endtask

   // hold the result channel off when a long stall is requested
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(negedge clock) begin
      slot_answer_t got;
      slot_answer_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.slot_index = rsp_slot_index;
         got.success    = rsp_success;
         if (pending_answers.size() == 0) begin
            flag_mismatch("unexpected beat", '0, got);
         end else begin
            want = pending_answers.pop_front();
            if (got.slot_index !== want.slot_index || got.success !== want.success)
               flag_mismatch("wrong result", want, got);
         end
      end
   end

   always @(negedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_process_slot_table failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int k = 0; k < SLOTS; k++) clear_slot(k);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_fill_and_drain();
      test_random_phase(170, 0, 0);
      test_random_phase(170, 49, 0);
      test_random_phase(170, 0, 49);
      test_random_phase(170, 7, 7);
      test_backpressure();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("tb_process_slot_table passed");
      end else begin
         $display("tb_process_slot_table failed");
      end
      $finish;
   end

endmodule
